// ===== rtl/lfsr_lc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the linear complexity block.
// No dependencies; every other file of the block depends on this package.
package lfsr_lc_pkg;

    localparam int WORD_W = 64;
    localparam int LC_W   = 14;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISC,
        ST_DLAST,
        ST_DECIDE,
        ST_UPD,
        ST_ULAST,
        ST_FINISH
    } lc_state_t;

    // Upper word of {hi, lo} shifted left by bs: one word of a polynomial times x^bs.
    function automatic logic [WORD_W-1:0] shift_word(input logic [WORD_W-1:0] hi,
                                                     input logic [WORD_W-1:0] lo,
                                                     input logic [5:0]        bs);
        logic [2*WORD_W-1:0] pair;
        begin
            pair = {hi, lo} << bs;
            return pair[2*WORD_W-1:WORD_W];
        end
    endfunction

endpackage

// ===== rtl/lfsr_lc_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input bits, the results and the configuration.
// Depends on lfsr_lc_pkg for the field widths.
interface lfsr_lc_bit_if;
    logic valid;
    logic ready;
    logic seq_bit;
    modport source (output valid, output seq_bit, input ready);
    modport sink (input valid, input seq_bit, output ready);
endinterface

interface lfsr_lc_out_if;
    logic                         valid;
    logic                         ready;
    logic [lfsr_lc_pkg::LC_W-1:0] linear_complexity;
    modport source (output valid, output linear_complexity, input ready);
    modport sink (input valid, input linear_complexity, output ready);
endinterface

interface lfsr_lc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [lfsr_lc_pkg::LC_W-1:0] block_length;
    modport source (output valid, output block_length, input ready);
    modport sink (input valid, input block_length, output ready);
endinterface

// ===== rtl/lfsr_lc_disc.sv =====
`timescale 1ns / 1ps
// One word of the discrepancy sum: aligns history bits against a connection word.
// Depends on lfsr_lc_pkg.
module lfsr_lc_disc #(
    parameter int AW = 7,
    parameter int PW = 13
) (
    input  logic [lfsr_lc_pkg::WORD_W-1:0] hi_word,
    input  logic [lfsr_lc_pkg::WORD_W-1:0] lo_word,
    input  logic [lfsr_lc_pkg::WORD_W-1:0] conn_word,
    input  logic [5:0]                     bit_ofs,
    input  logic [AW-1:0]                  word_idx,
    input  logic [PW-1:0]                  lim,
    output logic                           term
);
    import lfsr_lc_pkg::*;

    localparam int CW = ((AW + 7) > (PW + 1)) ? (AW + 7) : (PW + 1);

    logic [2*WORD_W-1:0] pair;
    logic [WORD_W-1:0]   window;
    logic [WORD_W-1:0]   rev;
    logic [WORD_W-1:0]   mask;
    logic [CW-1:0]       rem;

    always_comb
    begin
        // Bit 63 of the window is the history bit at position n - 64k.
        pair   = {hi_word, lo_word} >> (7'(bit_ofs) + 7'd1);
        window = pair[WORD_W-1:0];
        for (int t = 0; t < WORD_W; t++)
        begin
            rev[t] = window[WORD_W-1-t];
        end
        // Only terms 1 through min(L, n) take part.
        rem = CW'(lim) - (CW'(word_idx) << 6);
        if (rem >= CW'(WORD_W - 1))
        begin
            mask = '1;
        end
        else
        begin
            mask = ~({WORD_W{1'b1}} << (7'(rem[5:0]) + 7'd1));
        end
        if (word_idx == '0)
        begin
            mask[0] = 1'b0;
        end
        term = ^(conn_word & rev & mask);
    end

endmodule

// ===== rtl/lfsr_linear_complexity.sv =====
`timescale 1ns / 1ps
// Top level: Berlekamp-Massey linear complexity over GF(2) on blocks of input bits.
// Depends on lfsr_lc_pkg, the channel interfaces in lfsr_lc_if and lfsr_lc_disc.
//
//  Channel  Dir  Word carries                  Meaning
//  seq      in   seq_bit (1)                   next bit of the sequence
//  result   out  linear_complexity (14)        complexity of the finished block
//  cfg      in   block_length (14)             bits per block, 0 taken as 1
//
// Each accepted bit takes one pass over the connection words for the discrepancy and,
// when the discrepancy is one, a full pass over both polynomial memories for the
// update; the single read port of each memory sets the pace of both passes, and seq
// is not ready again until they finish. Reset is asynchronous and clears all control
// state; the polynomial memories read as their block-start value through per-word
// valid bits that are all cleared together at block end, so no clearing pass is
// needed. A waiting result does not block a new bit; only a block end that finds the
// result register still full stalls.
module lfsr_linear_complexity #(
    parameter int MAX_BLOCK = 8192
) (
    input  logic                clk,
    input  logic                rst_n,
    lfsr_lc_bit_if.sink         seq,
    lfsr_lc_out_if.source       result,
    lfsr_lc_cfg_if.sink         cfg
);
    import lfsr_lc_pkg::*;

    localparam int NWORDS = (MAX_BLOCK + WORD_W - 1) / WORD_W;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int PW     = $clog2(MAX_BLOCK);
    localparam int LW     = $clog2(MAX_BLOCK + 1);
    localparam int SW     = AW + 2;
    localparam int EW     = ((LW > LC_W) ? LW : LC_W) + 1;

    // Control state.
    lc_state_t state_reg, state_next;

    // Algorithm state.
    logic [PW-1:0]        n_reg;
    logic [LW-1:0]        l_reg;
    logic [LW-1:0]        lcp1_reg;       // last change position plus one
    logic [LC_W-1:0]      blen_reg;
    logic [WORD_W-1:0]    cur_word_reg;   // history word holding the current bit
    logic [PW-1:0]        lim_reg;
    logic [AW-1:0]        kmax_reg;
    logic [AW:0]          cnt_reg;
    logic                 d_reg;
    logic [WORD_W-1:0]    dh_prev_reg;
    logic [WORD_W-1:0]    up_prev_reg;
    logic [5:0]           bs_reg;
    logic signed [SW-1:0] ptop_reg;
    logic                 swap_reg;
    logic                 out_valid_reg;
    logic [LC_W-1:0]      out_data_reg;

    // Read pipeline tags.
    logic                 dvld_reg;
    logic [AW-1:0]        dk_reg;
    logic                 dlz_reg;
    logic                 uvld_reg;
    logic                 uprime_reg;
    logic [AW-1:0]        uw_reg;
    logic                 cn_w0_reg;
    logic                 pr_ok_reg;
    logic                 pr_w0_reg;

    // Memories and their valid bits.
    logic [WORD_W-1:0]    hist_mem [NWORDS];
    logic [WORD_W-1:0]    conn_mem [NWORDS];
    logic [WORD_W-1:0]    prev_mem [NWORDS];
    logic [NWORDS-1:0]    conn_vld_reg;
    logic [NWORDS-1:0]    prev_vld_reg;
    logic [WORD_W-1:0]    hist_q;
    logic [WORD_W-1:0]    conn_q;
    logic [WORD_W-1:0]    prev_q;
    logic                 conn_vq;
    logic                 prev_vq;

    // Combinational control.
    logic                 in_acc;
    logic [AW-1:0]        nw;
    logic [AW-1:0]        conn_raddr;
    logic [AW-1:0]        hist_raddr;
    logic [AW-1:0]        prev_raddr;
    logic signed [SW-1:0] p_idx;
    logic                 disc_issue;
    logic                 upd_issue;
    logic                 disc_done;
    logic                 upd_done;
    logic [WORD_W-1:0]    new_word;
    logic [WORD_W-1:0]    hi_d;
    logic [WORD_W-1:0]    lo_d;
    logic [WORD_W-1:0]    conn_e;
    logic [WORD_W-1:0]    prev_e;
    logic [WORD_W-1:0]    conn_new;
    logic                 term;
    logic [LW-1:0]        chg_dist;
    logic                 swap_c;
    logic [EW-1:0]        len_eff;
    logic                 blk_end;
    logic                 out_stall;

    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.linear_complexity = out_data_reg;

    // Output and addressing logic.
    always_comb
    begin
        seq.ready  = (state_reg == ST_IDLE);
        in_acc     = seq.valid && seq.ready;
        nw         = AW'(n_reg >> 6);
        disc_issue = (state_reg == ST_DISC);
        upd_issue  = (state_reg == ST_UPD);
        disc_done  = (cnt_reg[AW-1:0] == kmax_reg);
        upd_done   = (cnt_reg == (AW + 1)'(NWORDS));
        hist_raddr = nw - cnt_reg[AW-1:0] - AW'(1);
        p_idx      = ptop_reg - $signed(SW'(cnt_reg));
        prev_raddr = p_idx[AW-1:0];
        if (upd_issue)
        begin
            conn_raddr = AW'((AW + 1)'(NWORDS) - cnt_reg);
        end
        else
        begin
            conn_raddr = cnt_reg[AW-1:0];
        end

        // The new bit lands in the current history word; a fresh word starts at bit 0.
        new_word = (n_reg[5:0] == 6'd0) ? '0 : cur_word_reg;
        new_word[n_reg[5:0]] = seq.seq_bit;

        // Words that were never written this block read as their block-start value.
        conn_e = conn_vq ? conn_q : (cn_w0_reg ? WORD_W'(1) : '0);
        if (!pr_ok_reg)
        begin
            prev_e = '0;
        end
        else
        begin
            prev_e = prev_vq ? prev_q : (pr_w0_reg ? WORD_W'(1) : '0);
        end
        hi_d     = (dk_reg == '0) ? cur_word_reg : dh_prev_reg;
        lo_d     = dlz_reg ? '0 : hist_q;
        conn_new = conn_e ^ shift_word(up_prev_reg, prev_e, bs_reg);

        chg_dist = LW'(n_reg) + LW'(1) - lcp1_reg;
        swap_c   = ({1'b0, l_reg, 1'b0} <= (LW + 2)'(n_reg));

        if (blen_reg == '0)
        begin
            len_eff = EW'(1);
        end
        else if (EW'(blen_reg) > EW'(MAX_BLOCK))
        begin
            len_eff = EW'(MAX_BLOCK);
        end
        else
        begin
            len_eff = EW'(blen_reg);
        end
        blk_end   = (EW'(n_reg) + EW'(1)) >= len_eff;
        out_stall = out_valid_reg && !result.ready;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_acc) state_next = ST_DISC;
            ST_DISC:   if (disc_done) state_next = ST_DLAST;
            ST_DLAST:  state_next = ST_DECIDE;
            ST_DECIDE: state_next = d_reg ? ST_UPD : ST_FINISH;
            ST_UPD:    if (upd_done) state_next = ST_ULAST;
            ST_ULAST:  state_next = ST_FINISH;
            ST_FINISH: if (!(blk_end && out_stall)) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    lfsr_lc_disc #(
        .AW (AW),
        .PW (PW)
    ) u_disc (
        .hi_word   (hi_d),
        .lo_word   (lo_d),
        .conn_word (conn_e),
        .bit_ofs   (n_reg[5:0]),
        .word_idx  (dk_reg),
        .lim       (lim_reg),
        .term      (term)
    );

    // History memory: written once per bit, read descending during the discrepancy pass.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            hist_mem[nw] <= new_word;
        end
        hist_q <= hist_mem[hist_raddr];
    end

    // Polynomial memories: conn rewritten in the update pass, prev only on a swap.
    always_ff @(posedge clk)
    begin
        if (uvld_reg)
        begin
            conn_mem[uw_reg] <= conn_new;
            if (swap_reg)
            begin
                prev_mem[uw_reg] <= conn_e;
            end
        end
        conn_q <= conn_mem[conn_raddr];
        prev_q <= prev_mem[prev_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conn_vld_reg <= '0;
            prev_vld_reg <= '0;
            conn_vq      <= 1'b0;
            prev_vq      <= 1'b0;
        end
        else
        begin
            conn_vq <= conn_vld_reg[conn_raddr];
            prev_vq <= prev_vld_reg[prev_raddr];
            if (state_reg == ST_FINISH && blk_end && !out_stall)
            begin
                conn_vld_reg <= '0;
                prev_vld_reg <= '0;
            end
            else if (uvld_reg)
            begin
                conn_vld_reg[uw_reg] <= 1'b1;
                if (swap_reg)
                begin
                    prev_vld_reg[uw_reg] <= 1'b1;
                end
            end
        end
    end

    // Configuration and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blen_reg      <= LC_W'(500);
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                blen_reg <= cfg.block_length;
            end
            if (state_reg == ST_FINISH && blk_end && !out_stall)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= LC_W'(l_reg);
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Sequencer and algorithm state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            n_reg        <= '0;
            l_reg        <= '0;
            lcp1_reg     <= '0;
            cur_word_reg <= '0;
            lim_reg      <= '0;
            kmax_reg     <= '0;
            cnt_reg      <= '0;
            d_reg        <= 1'b0;
            dh_prev_reg  <= '0;
            up_prev_reg  <= '0;
            bs_reg       <= '0;
            ptop_reg     <= '0;
            swap_reg     <= 1'b0;
            dvld_reg     <= 1'b0;
            dk_reg       <= '0;
            dlz_reg      <= 1'b0;
            uvld_reg     <= 1'b0;
            uprime_reg   <= 1'b0;
            uw_reg       <= '0;
            cn_w0_reg    <= 1'b0;
            pr_ok_reg    <= 1'b0;
            pr_w0_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            dvld_reg   <= disc_issue;
            uvld_reg   <= upd_issue && (cnt_reg != '0);
            uprime_reg <= upd_issue && (cnt_reg == '0);
            cn_w0_reg  <= (conn_raddr == '0);
            pr_ok_reg  <= !p_idx[SW-1];
            pr_w0_reg  <= (p_idx == '0);

            // Discrepancy data stage: the low word here is the high word of the next one.
            if (dvld_reg)
            begin
                d_reg       <= d_reg ^ term;
                dh_prev_reg <= lo_d;
            end
            // Update data stage walks the words downward, carrying the higher prev word.
            if (uvld_reg || uprime_reg)
            begin
                up_prev_reg <= prev_e;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        cur_word_reg <= new_word;
                        d_reg        <= seq.seq_bit;
                        cnt_reg      <= '0;
                        if (LW'(n_reg) < l_reg)
                        begin
                            lim_reg  <= n_reg;
                            kmax_reg <= AW'(n_reg >> 6);
                        end
                        else
                        begin
                            lim_reg  <= PW'(l_reg);
                            kmax_reg <= AW'(l_reg >> 6);
                        end
                    end
                end
                ST_DISC:
                begin
                    dk_reg  <= cnt_reg[AW-1:0];
                    dlz_reg <= (cnt_reg[AW-1:0] == nw);
                    cnt_reg <= cnt_reg + (AW + 1)'(1);
                end
                ST_DLAST:
                begin
                    cnt_reg <= '0;
                end
                ST_DECIDE:
                begin
                    if (d_reg)
                    begin
                        bs_reg   <= chg_dist[5:0];
                        ptop_reg <= $signed(SW'(NWORDS - 1)) - $signed(SW'(chg_dist >> 6));
                        swap_reg <= swap_c;
                        cnt_reg  <= '0;
                        if (swap_c)
                        begin
                            l_reg    <= LW'(n_reg) + LW'(1) - l_reg;
                            lcp1_reg <= LW'(n_reg) + LW'(1);
                        end
                    end
                end
                ST_UPD:
                begin
                    uw_reg  <= conn_raddr;
                    cnt_reg <= cnt_reg + (AW + 1)'(1);
                end
                ST_ULAST:
                begin
                    cnt_reg <= '0;
                end
                ST_FINISH:
                begin
                    if (blk_end)
                    begin
                        if (!out_stall)
                        begin
                            n_reg    <= '0;
                            l_reg    <= '0;
                            lcp1_reg <= '0;
                        end
                    end
                    else
                    begin
                        n_reg <= n_reg + PW'(1);
                    end
                end
                default:
                begin
                    cnt_reg <= '0;
                end
            endcase
        end
    end

endmodule
